FILE: rtl/core/multichannel_pedestal_subtractor_top_defines.svh
// assertion macros for the pedestal subtractor top level
`ifndef MULTICHANNEL_PEDESTAL_SUBTRACTOR_TOP_DEFINES_SVH
`define MULTICHANNEL_PEDESTAL_SUBTRACTOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet while rst_n is low
`define MPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, quiet while rst_n is low
`define MPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mps_pkg.sv
// types and constants of the pedestal subtractor
package mps_pkg;

    localparam int RAW_W      = 16;
    localparam int FLAG_W     = 3;
    localparam int ACC_W      = 5;
    localparam int ACC_LIMIT  = 10;
    localparam int CORR_W     = 13;
    localparam int CHAN_OUT_W = 6;
    localparam int PED_OUT_W  = 12;
    localparam int CNT_W      = 7;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INIT_PED   = 1'b0,
        CFG_CHAN_COUNT = 1'b1
    } cfg_idx_t;

    // one result item as it leaves the block
    typedef struct packed {
        logic signed [CORR_W-1:0] corrected_sample;
        logic [CHAN_OUT_W-1:0]    channel_index;
        logic [PED_OUT_W-1:0]     pedestal_now;
        logic                     processed;
    } out_item_t;

endpackage

FILE: rtl/core/mps_ram.sv
// generic single-write, single-read ram with registered read
module mps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/mps_chan.sv
// channel pointer: advances on end of packet, wraps at the channel count
module mps_chan
    import mps_pkg::*;
#(
    parameter int MAX_CHANNELS = 64,
    parameter int CW           = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             eop,
    input  logic             clear,
    input  logic [CNT_W-1:0] channel_count,
    output logic [CW-1:0]    ch
);

    localparam int EW = (CW + 1 > CNT_W) ? CW + 1 : CNT_W;

    logic [CW-1:0] ch_reg;
    logic [CW-1:0] ch_next;
    logic [EW-1:0] cnt_ext;
    logic [EW-1:0] max_ext;
    logic [EW-1:0] eff;
    logic [EW-1:0] inc;

    assign cnt_ext = EW'(channel_count);
    assign max_ext = EW'(MAX_CHANNELS);

    always_comb
    begin
        // zero counts as one, anything above the store size is clamped
        if (cnt_ext == '0)
        begin
            eff = EW'(1);
        end
        else if (cnt_ext > max_ext)
        begin
            eff = max_ext;
        end
        else
        begin
            eff = cnt_ext;
        end
        inc = EW'(ch_reg) + EW'(1);
        if (clear)
        begin
            ch_next = '0;
        end
        else if (step && eop)
        begin
            ch_next = (inc >= eff) ? '0 : inc[CW-1:0];
        end
        else
        begin
            ch_next = ch_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg <= '0;
        end
        else
        begin
            ch_reg <= ch_next;
        end
    end

    assign ch = ch_reg;

endmodule

FILE: rtl/core/mps_update.sv
// per-sample pedestal tracking step and subtraction
module mps_update
    import mps_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int PED_W       = 12
) (
    input  logic                     go,
    input  logic [SAMPLE_BITS-1:0]   sample,
    input  logic [PED_W-1:0]         ped,
    input  logic signed [ACC_W-1:0]  acc,
    output logic [PED_W-1:0]         ped_new,
    output logic signed [ACC_W-1:0]  acc_new,
    output logic signed [CORR_W-1:0] corr
);

    logic [PED_W-1:0]        sample_ext;
    logic signed [ACC_W-1:0] acc_mv;
    logic signed [PED_W:0]   diff;

    assign sample_ext = PED_W'(sample);

    always_comb
    begin
        if (sample_ext > ped)
        begin
            acc_mv = acc + ACC_W'(1);
        end
        else if (sample_ext < ped)
        begin
            acc_mv = acc - ACC_W'(1);
        end
        else
        begin
            acc_mv = acc;
        end

        ped_new = ped;
        acc_new = acc;
        if (go)
        begin
            if (acc_mv >= ACC_W'(ACC_LIMIT))
            begin
                ped_new = ped + PED_W'(1);
                acc_new = '0;
            end
            else if (acc_mv <= -ACC_W'(ACC_LIMIT))
            begin
                ped_new = ped - PED_W'(1);
                acc_new = '0;
            end
            else
            begin
                acc_new = acc_mv;
            end
        end

        diff = $signed({1'b0, sample_ext}) - $signed({1'b0, ped_new});
        corr = go ? diff[CORR_W-1:0] : '0;
    end

endmodule

FILE: rtl/core/multichannel_pedestal_subtractor_top.sv
// top level of the multichannel running-median pedestal subtractor
//
//  group   dir  handshake          payload
//  s_*     in   s_tvalid/s_tready  raw word in tdata, valid/keep flags in tuser, tlast
//  m_*     out  m_tvalid/m_tready  corrected, channel, pedestal in tdata, processed in tuser
//  cfg_*   in   cfg_we only        register index and data, no read-back
//
// one item per clock unless m_tready stalls; update stage register, then output register
// the per-channel state ram has a registered read; back-to-back items on
// the same channel are served by a write-to-read bypass
// reset (and a write of initial_pedestal) drops all entry valid bits at once,
// so there is no clearing pass
// a stall on m_tready with a full output holds the update stage; s_tready drops in the same cycle if that stage is full
`include "multichannel_pedestal_subtractor_top_defines.svh"

module multichannel_pedestal_subtractor_top
    import mps_pkg::*;
#(
    parameter int MAX_CHANNELS = 64,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // stream in
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [RAW_W-1:0]      s_tdata,   // raw_word[15:0]
    input  logic [FLAG_W-1:0]     s_tuser,   // data_valid, keep_low, keep_high
    input  logic                  s_tlast,   // end_of_packet
    // stream out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // corrected_sample[12:0], channel_index[18:13],
                                             // pedestal_now[30:19], zero pad
    output logic                  m_tuser,   // processed
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // channel pointer width and pedestal width (pedestal can climb to full sample range)
    localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PED_W = (SAMPLE_BITS > PED_OUT_W) ? SAMPLE_BITS : PED_OUT_W;
    localparam int ENT_W = PED_W + ACC_W;

    // configuration registers
    logic [PED_OUT_W-1:0] init_ped_reg;
    logic [CNT_W-1:0]     chan_count_reg;
    logic                 cfg_clear;

    // handshake
    logic s_accept;
    logic s1_adv;

    // channel pointer
    logic [CW-1:0] ch;

    // state ram and entry valid bits
    logic                 ram_we;
    logic [ENT_W-1:0]     ram_wdata;
    logic [ENT_W-1:0]     ram_rdata;
    logic [MAX_CHANNELS-1:0] vld_reg;
    logic [MAX_CHANNELS-1:0] vld_next;

    // update stage
    logic                   s1_valid_reg;
    logic                   s1_go_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [CW-1:0]          s1_ch_reg;
    logic                   rd_vld_reg;
    logic                   fwd_reg;
    logic [ENT_W-1:0]       fwd_data_reg;
    logic [ENT_W-1:0]       entry;

    logic [PED_W-1:0]         upd_ped_new;
    logic signed [ACC_W-1:0]  upd_acc_new;
    logic signed [CORR_W-1:0] upd_corr;

    // output register
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;

    assign cfg_clear = cfg_we && (cfg_idx_t'(cfg_index) == CFG_INIT_PED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_ped_reg   <= '0;
            chan_count_reg <= CNT_W'(64);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_INIT_PED:   init_ped_reg   <= cfg_data;
                CFG_CHAN_COUNT: chan_count_reg <= cfg_data[CNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // update stage moves when the output register is free or being emptied
    assign s1_adv   = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_accept = s_tvalid && s_tready;

    mps_chan #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .CW           (CW)
    ) u_chan (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (s_accept),
        .eop           (s_tlast),
        .clear         (cfg_clear),
        .channel_count (chan_count_reg),
        .ch            (ch)
    );

    // entry: pedestal in the upper bits, accumulator in the lower
    mps_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_CHANNELS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_ch_reg),
        .wdata (ram_wdata),
        .re    (s_accept),
        .raddr (ch),
        .rdata (ram_rdata)
    );

    assign ram_we    = s1_valid_reg && s1_go_reg && s1_adv;
    assign ram_wdata = {upd_ped_new, upd_acc_new};

    always_comb
    begin
        vld_next = vld_reg;
        if (ram_we)
        begin
            vld_next[s1_ch_reg] = 1'b1;
        end
        if (cfg_clear)
        begin
            vld_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // capture the item; bypass the write that lands in the same cycle as the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= ram_we && (s1_ch_reg == ch);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_go_reg     <= &s_tuser;
            s1_sample_reg <= s_tdata[SAMPLE_BITS-1:0];
            s1_ch_reg     <= ch;
            rd_vld_reg    <= vld_reg[ch];
            fwd_data_reg  <= ram_wdata;
        end
    end

    // never-written entries read as initial_pedestal with a zero accumulator
    always_comb
    begin
        if (fwd_reg)
        begin
            entry = fwd_data_reg;
        end
        else if (rd_vld_reg)
        begin
            entry = ram_rdata;
        end
        else
        begin
            entry = {PED_W'(init_ped_reg), {ACC_W{1'b0}}};
        end
    end

    mps_update #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .PED_W       (PED_W)
    ) u_update (
        .go      (s1_go_reg),
        .sample  (s1_sample_reg),
        .ped     (entry[ENT_W-1:ACC_W]),
        .acc     ($signed(entry[ACC_W-1:0])),
        .ped_new (upd_ped_new),
        .acc_new (upd_acc_new),
        .corr    (upd_corr)
    );

    always_comb
    begin
        out_item_next.corrected_sample = upd_corr;
        out_item_next.channel_index    = CHAN_OUT_W'(s1_ch_reg);
        out_item_next.pedestal_now     = PED_OUT_W'(upd_ped_new);
        out_item_next.processed        = s1_go_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'({out_item_reg.pedestal_now,
                                   out_item_reg.channel_index,
                                   out_item_reg.corrected_sample});
    assign m_tuser  = out_item_reg.processed;

    // ram writes only come from an update stage item that is moving on
    `MPS_ASSERT_NOW(a_we_src, ram_we, s1_valid_reg && s1_go_reg && s1_adv, "stray state write")
    // the accumulator written back never sits at the step threshold
    `MPS_ASSERT_NOW(a_acc_bound, ram_we,
        (upd_acc_new < ACC_W'(ACC_LIMIT)) && (upd_acc_new > -ACC_W'(ACC_LIMIT)),
        "accumulator out of range")
    // a pedestal reload restarts at channel zero with every entry unwritten
    `MPS_ASSERT_NEXT(a_cfg_clear, cfg_clear, (ch == '0) && (vld_reg == '0),
        "reload did not clear state")
    // channel pointer stays inside the store
    `MPS_ASSERT_NOW(a_ch_range, 1'b1, 32'(ch) < MAX_CHANNELS, "channel outside store")
    // an accepted item always occupies the update stage next cycle
    `MPS_ASSERT_NEXT(a_s1_fill, s_accept, s1_valid_reg, "accepted item lost")

endmodule

FILE: test/tb_multichannel_pedestal_subtractor_top.sv
// self-checking testbench for the multichannel pedestal subtractor top level
`timescale 1ns / 100ps

module tb_multichannel_pedestal_subtractor_top;
    import mps_pkg::*;

    localparam int SAMPLE_W    = 12;
    localparam int CHANNELS    = 64;
    localparam int QUIET_LIMIT = 2000;   // cycles with no item moving before giving up
    localparam int LONG_HOLD   = 80;     // receiver hold-off, well past the pipeline depth
    localparam int ITEM_TARGET = 950;

    // flag groups as carried in s_tuser: {keep_high, keep_low, data_valid}
    localparam logic [FLAG_W-1:0] FLAGS_ALL     = 3'b111;
    localparam logic [FLAG_W-1:0] FLAGS_NO_VAL  = 3'b110;
    localparam logic [FLAG_W-1:0] FLAGS_NO_KLO  = 3'b101;
    localparam logic [FLAG_W-1:0] FLAGS_NO_KHI  = 3'b011;
    localparam logic [FLAG_W-1:0] FLAGS_NONE    = 3'b000;

    typedef struct packed {
        logic [RAW_W-1:0] raw_word;
        logic             keep_high;
        logic             keep_low;
        logic             data_valid;
        logic             end_of_packet;
    } word_item_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [RAW_W-1:0]      s_tdata;
    logic [FLAG_W-1:0]     s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    multichannel_pedestal_subtractor_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // words waiting to go in, corrected results waiting to come out
    word_item_t words_to_send[$];
    out_item_t  corrected_due[$];

    // own copy of the per-channel state and the registers
    logic [PED_OUT_W-1:0] ped_est[CHANNELS];
    int                   acc_est[CHANNELS];
    int                   chan_est;
    logic [PED_OUT_W-1:0] init_ped_reg;
    logic [CNT_W-1:0]     chan_count_reg;

    // traffic shaping knobs, changed per phase by the stimulus block
    bit gaps_on;
    int stall_pct;
    bit hold_req;
    int hold_left;
    int stall_left;
    int burst_left;
    int gap_left;
    bit item_taken;

    // stimulus shaping
    int level;
    int pkt_left;

    int mismatches;
    int quiet_cycles;
    int results_seen;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // reload every channel, as a reset or an initial_pedestal write does
    function automatic void clear_channels();
        for (int k = 0; k < CHANNELS; k++)
        begin
            ped_est[k] = init_ped_reg;
            acc_est[k] = 0;
        end
        chan_est = 0;
    endfunction

    // one step of the running-median tracker: update the channel, build its result
    function automatic out_item_t track_pedestal(input word_item_t w);
        out_item_t            r;
        logic                 go;
        logic [SAMPLE_W-1:0]  samp;
        logic [PED_OUT_W-1:0] ped;
        int                   acc;
        int                   ch;
        int                   diff;
        int                   wrap_at;
        ch   = chan_est;
        go   = w.data_valid & w.keep_low & w.keep_high;
        ped  = ped_est[ch];
        acc  = acc_est[ch];
        samp = w.raw_word[SAMPLE_W-1:0];
        r.corrected_sample = '0;
        if (go)
        begin
            if (samp > ped)
                acc++;
            else if (samp < ped)
                acc--;
            // accumulator full in either direction: nudge the pedestal and start over
            if (acc >= ACC_LIMIT)
            begin
                ped++;
                acc = 0;
            end
            else if (acc <= -ACC_LIMIT)
            begin
                ped--;
                acc = 0;
            end
            ped_est[ch] = ped;
            acc_est[ch] = acc;
            diff = int'(samp) - int'(ped);
            r.corrected_sample = diff[CORR_W-1:0];
        end
        r.channel_index = ch[CHAN_OUT_W-1:0];
        r.pedestal_now  = ped;
        r.processed     = go;
        // end of packet moves on; a zero count behaves as one, oversize as the full set
        if (w.end_of_packet)
        begin
            wrap_at = int'(chan_count_reg);
            if (wrap_at == 0)
                wrap_at = 1;
            if (wrap_at > CHANNELS)
                wrap_at = CHANNELS;
            chan_est = (ch + 1 >= wrap_at) ? 0 : ch + 1;
        end
        return r;
    endfunction

    function automatic word_item_t mk_word(input logic [RAW_W-1:0] raw,
                                           input logic [FLAG_W-1:0] fl, input logic eop);
        word_item_t w;
        w.raw_word      = raw;
        {w.keep_high, w.keep_low, w.data_valid} = fl;
        w.end_of_packet = eop;
        return w;
    endfunction

    // well-formed words around a drifting level, with some noise and broken flags
    function automatic word_item_t random_word();
        word_item_t w;
        int         samp;
        logic [FLAG_W-1:0] fl;
        logic       eop;
        logic [RAW_W-1:0] raw;
        if ($urandom_range(0, 15) == 0)
        begin
            level = level + (($urandom_range(0, 1) == 1) ? 1 : -1);
            if (level < 0)
                level = 0;
            if (level > 4095)
                level = 4095;
        end
        if ($urandom_range(0, 9) == 0)
            raw = 16'($urandom);
        else
        begin
            samp = level + int'($urandom_range(0, 10)) - 5;
            if (samp < 0)
                samp = 0;
            if (samp > 4095)
                samp = 4095;
            raw = {4'($urandom), 12'(samp)};
        end
        if ($urandom_range(0, 9) == 0)
            fl = 3'($urandom);
        else
            fl = FLAGS_ALL;
        // packets of random length, the last word carries the end marker
        if (pkt_left == 0)
        begin
            eop      = 1'b1;
            pkt_left = $urandom_range(0, 7);
        end
        else
        begin
            eop = 1'b0;
            pkt_left--;
        end
        w = mk_word(raw, fl, eop);
        return w;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 40)
            $display("mismatch at result %0d: %s got %0d, expected %0d",
                     results_seen, what, got, want);
        mismatches++;
    endtask

    // register write while the block is idle; the shadow copy follows at once
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_INIT_PED)
        begin
            init_ped_reg = value[PED_OUT_W-1:0];
            clear_channels();
        end
        else
            chan_count_reg = value[CNT_W-1:0];
    endtask

    // sender holds off until every word is in and every result is out
    task automatic wait_drained();
        while (words_to_send.size() != 0 || corrected_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // driver: bursts of random length with random gaps when gaps_on is set, fed from words_to_send
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (s_tvalid && !item_taken)
            ;   // item still on offer, hold it
        else if (gap_left > 0)
        begin
            s_tvalid <= 1'b0;
            gap_left--;
        end
        else if (words_to_send.size() != 0)
        begin
            s_tvalid <= 1'b1;
            s_tdata  <= words_to_send[0].raw_word;
            s_tuser  <= {words_to_send[0].keep_high, words_to_send[0].keep_low,
                         words_to_send[0].data_valid};
            s_tlast  <= words_to_send[0].end_of_packet;
            if (burst_left > 0)
                burst_left--;
            else
            begin
                burst_left = $urandom_range(0, 20);
                gap_left   = gaps_on ? $urandom_range(1, 8) : 0;
            end
        end
        else
            s_tvalid <= 1'b0;
        item_taken = 1'b0;
    end

    // receiver: random stall runs, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else if (int'($urandom_range(0, 99)) < stall_pct)
        begin
            m_tready   <= 1'b0;
            stall_left = $urandom_range(0, 6);
        end
        else
            m_tready <= 1'b1;
    end

    // accepted words are predicted, accepted results checked, idle cycles counted
    always @(posedge clk)
    begin : item_monitor
        out_item_t  want;
        word_item_t sent;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                sent = words_to_send.pop_front();
                corrected_due.push_back(track_pedestal(sent));
                item_taken = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                if (corrected_due.size() == 0)
                    report_mismatch("result with nothing outstanding", 1, 0);
                else
                begin
                    want = corrected_due.pop_front();
                    if ($signed(m_tdata[12:0]) != want.corrected_sample)
                        report_mismatch("corrected_sample", $signed(m_tdata[12:0]),
                                        want.corrected_sample);
                    if (m_tdata[18:13] != want.channel_index)
                        report_mismatch("channel_index", m_tdata[18:13], want.channel_index);
                    if (m_tdata[30:19] != want.pedestal_now)
                        report_mismatch("pedestal_now", m_tdata[30:19], want.pedestal_now);
                    if (m_tuser != want.processed)
                        report_mismatch("processed", m_tuser, want.processed);
                end
                results_seen++;
            end
            // watchdog on lack of progress
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: nothing moved for %0d cycles", QUIET_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int             sent_total;
        int             n;
        int             phase_no;
        logic [CNT_W-1:0] cnt;
        logic [PED_OUT_W-1:0] ped0;
        bit             do_init;
        // every input known from time zero
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        s_tlast    = 1'b0;
        m_tready   = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_INIT_PED;
        cfg_data   = '0;
        gaps_on    = 1'b1;
        stall_pct  = 20;
        hold_req   = 1'b0;
        hold_left  = 0;
        stall_left = 0;
        burst_left = 0;
        gap_left   = 0;
        item_taken = 1'b0;
        level      = 0;
        pkt_left   = 0;
        mismatches   = 0;
        quiet_cycles = 0;
        results_seen = 0;
        sent_total   = 0;
        init_ped_reg   = '0;
        chan_count_reg = 7'd64;
        clear_channels();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset values: pedestal zero, all 64 channels
        words_to_send.push_back(mk_word(16'hFFFF, FLAGS_ALL, 1'b0));    // largest sample
        words_to_send.push_back(mk_word(16'hF000, FLAGS_ALL, 1'b0));    // equal to pedestal
        words_to_send.push_back(mk_word(16'h0ABC, FLAGS_NO_VAL, 1'b0)); // not valid
        words_to_send.push_back(mk_word(16'h0ABC, FLAGS_NO_KLO, 1'b0)); // low keep missing
        words_to_send.push_back(mk_word(16'h0ABC, FLAGS_NO_KHI, 1'b1)); // high keep missing, next
        // ten samples above on channel one: pedestal steps up on the tenth
        for (int k = 0; k < 10; k++)
            words_to_send.push_back(mk_word({4'($urandom), 12'h001}, FLAGS_ALL, k == 9));
        words_to_send.push_back(mk_word(16'hFFFF, FLAGS_NONE, 1'b1));
        sent_total += 16;
        wait_drained();

        // top pedestal and a zero channel count: channel stays at zero
        write_reg(CFG_INIT_PED, 12'hFFF);
        write_reg(CFG_CHAN_COUNT, 12'h000);
        words_to_send.push_back(mk_word(16'h0000, FLAGS_ALL, 1'b1));    // most negative result
        words_to_send.push_back(mk_word(16'hFFFF, FLAGS_ALL, 1'b1));
        words_to_send.push_back(mk_word(16'h1234, FLAGS_NONE, 1'b1));
        sent_total += 3;
        wait_drained();

        // oversize count (upper data bits set too) behaves as the full set
        write_reg(CFG_INIT_PED, 12'h800);
        write_reg(CFG_CHAN_COUNT, 12'hF7F);
        for (int k = 0; k < 6; k++)
            words_to_send.push_back(mk_word(16'($urandom), FLAGS_ALL, 1'b1));
        sent_total += 6;
        wait_drained();

        // count lowered below the current channel: next end of packet goes home
        write_reg(CFG_CHAN_COUNT, 12'h003);
        words_to_send.push_back(mk_word(16'($urandom), FLAGS_ALL, 1'b1));
        words_to_send.push_back(mk_word(16'($urandom), FLAGS_ALL, 1'b1));
        sent_total += 2;
        wait_drained();

        // random phases, each with its own settings and traffic shape
        phase_no = 0;
        level    = 2048;
        while (sent_total < ITEM_TARGET)
        begin
            case ($urandom_range(0, 5))
                0:       cnt = 7'd1;
                1:       cnt = 7'd2;
                2:       cnt = 7'd3;
                3:       cnt = 7'd64;
                4:       cnt = 7'($urandom_range(0, 127));
                default: cnt = ($urandom_range(0, 1) == 1) ? 7'd127 : 7'd0;
            endcase
            do_init = ($urandom_range(0, 2) != 0);
            if (do_init)
            begin
                case ($urandom_range(0, 3))
                    0:       ped0 = 12'h000;
                    1:       ped0 = 12'hFFF;
                    default: ped0 = 12'($urandom);
                endcase
                write_reg(CFG_INIT_PED, ped0);
                // aim the samples a little off the new pedestal so it walks
                level = int'(ped0) + int'($urandom_range(0, 60)) - 30;
                if (level < 0)
                    level = 0;
                if (level > 4095)
                    level = 4095;
            end
            write_reg(CFG_CHAN_COUNT, {5'($urandom), cnt});

            gaps_on   = ($urandom_range(0, 3) != 0);
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(5, 50));
            // long receiver hold-off with the sender offering without gaps
            if (phase_no == 1 || phase_no == 6)
            begin
                gaps_on  = 1'b0;
                hold_req = 1'b1;
            end
            n = $urandom_range(60, 100);
            for (int k = 0; k < n; k++)
                words_to_send.push_back(random_word());
            sent_total += n;
            wait_drained();
            phase_no++;
        end

        // let any stray result surface before the verdict
        repeat (10) @(posedge clk);
        if (corrected_due.size() != 0)
            report_mismatch("results still outstanding", 0, corrected_due.size());
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: multichannel_pedestal_subtractor_top.f
+incdir+rtl/core
rtl/core/mps_pkg.sv
rtl/core/mps_ram.sv
rtl/core/mps_chan.sv
rtl/core/mps_update.sv
rtl/core/multichannel_pedestal_subtractor_top.sv
test/tb_multichannel_pedestal_subtractor_top.sv
